>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked while out of reset
`define BGC_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgc assertion failed");

// next-cycle implication checked while out of reset
`define BGC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgc assertion failed");

// implication checked on every edge, reset included
`define BGC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("bgc assertion failed");

`endif

>>> sv/bgc_pkg.sv
package bgc_pkg;

  localparam int FREQ_W      = 16;
  localparam int GAIN_W      = 17;
  localparam int ORDER_W     = 5;
  localparam int Q16_W       = 32;
  localparam int RATIO_STEPS = 33;
  localparam int POW_STAGES  = 62;
  localparam int GAIN_STEPS  = 17;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam logic [Q16_W-1:0]  Q16_ONE  = 32'h0001_0000;
  localparam logic [Q16_W-1:0]  Q16_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_BAND  = 2'd0,
    MODE_LOW   = 2'd1,
    MODE_HIGH  = 2'd2,
    MODE_NOTCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_LOW_CUT  = 2'd1,
    REG_HIGH_CUT = 2'd2,
    REG_ORDER    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              force_en;
    logic [GAIN_W-1:0] force_val;
    logic              notch;
  } side_t;

endpackage

>>> sv/bgc_ratio_div.sv
module bgc_ratio_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [bgc_pkg::Q16_W-1:0]  num,
  input  logic [bgc_pkg::Q16_W-1:0]  den,
  input  bgc_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [bgc_pkg::Q16_W-1:0]  ratio,
  output bgc_pkg::side_t             out_side
);
  import bgc_pkg::*;

  logic                   v    [0:RATIO_STEPS];
  logic [Q16_W-1:0]       rem  [0:RATIO_STEPS];
  logic [RATIO_STEPS-1:0] dvd  [0:RATIO_STEPS];
  logic [RATIO_STEPS-1:0] quo  [0:RATIO_STEPS];
  logic [Q16_W-1:0]       dn   [0:RATIO_STEPS];
  logic                   sat  [0:RATIO_STEPS];
  side_t                  sd   [0:RATIO_STEPS];

  logic [Q16_W-1:0] rem_nx [0:RATIO_STEPS-1];
  logic             ge     [0:RATIO_STEPS-1];
  logic [Q16_W:0]   trial  [0:RATIO_STEPS-1];
  logic [Q16_W:0]   diff   [0:RATIO_STEPS-1];
  logic [RATIO_STEPS:0] rounded;

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < RATIO_STEPS; k++) begin
      trial[k]  = {rem[k], dvd[k][RATIO_STEPS-1]};
      diff[k]   = trial[k] - {1'b0, dn[k]};
      ge[k]     = trial[k] >= {1'b0, dn[k]};
      rem_nx[k] = ge[k] ? diff[k][Q16_W-1:0] : trial[k][Q16_W-1:0];
    end
  end

  assign rounded = ({1'b0, quo[RATIO_STEPS]} + {{RATIO_STEPS{1'b0}}, 1'b1}) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= RATIO_STEPS; k++) v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v[0] <= in_valid;
      for (int k = 0; k < RATIO_STEPS; k++) v[k+1] <= v[k];
      out_valid <= v[RATIO_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= {16'b0, num[Q16_W-1:16]};
      dvd[0] <= {num[15:0], 17'b0};
      quo[0] <= '0;
      dn[0]  <= den;
      sat[0] <= {16'b0, num} >= {den, 16'b0};
      sd[0]  <= in_side;
      for (int k = 0; k < RATIO_STEPS; k++) begin
        rem[k+1] <= rem_nx[k];
        dvd[k+1] <= {dvd[k][RATIO_STEPS-2:0], 1'b0};
        quo[k+1] <= {quo[k][RATIO_STEPS-2:0], ge[k]};
        dn[k+1]  <= dn[k];
        sat[k+1] <= sat[k];
        sd[k+1]  <= sd[k];
      end
      ratio    <= (sat[RATIO_STEPS] || rounded[Q16_W]) ? Q16_MAX : rounded[Q16_W-1:0];
      out_side <= sd[RATIO_STEPS];
    end
  end

endmodule

>>> sv/bgc_power.sv
module bgc_power (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic [bgc_pkg::ORDER_W-1:0]  order,
  input  logic                         in_valid,
  input  logic [bgc_pkg::Q16_W-1:0]    ratio,
  input  bgc_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [bgc_pkg::Q16_W-1:0]    power,
  output bgc_pkg::side_t               out_side
);
  import bgc_pkg::*;

  logic             v  [0:POW_STAGES];
  logic [Q16_W-1:0] p  [0:POW_STAGES];
  logic [Q16_W-1:0] r  [0:POW_STAGES];
  side_t            sd [0:POW_STAGES];

  logic [2*Q16_W-1:0] prod  [0:POW_STAGES-1];
  logic [2*Q16_W:0]   rnd   [0:POW_STAGES-1];
  logic [Q16_W-1:0]   p_nx  [0:POW_STAGES-1];
  logic [ORDER_W:0]   steps;

  assign steps = {order, 1'b0};

  // one rounded, saturated multiply per stage
  always_comb begin
    for (int k = 0; k < POW_STAGES; k++) begin
      prod[k] = {{Q16_W{1'b0}}, p[k]} * {{Q16_W{1'b0}}, r[k]};
      rnd[k]  = {1'b0, prod[k]} + (2*Q16_W+1)'(32768);
      if ((ORDER_W+1)'(k) >= steps) begin
        p_nx[k] = p[k];
      end else if (|rnd[k][2*Q16_W:Q16_W+16]) begin
        p_nx[k] = Q16_MAX;
      end else begin
        p_nx[k] = rnd[k][Q16_W+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= POW_STAGES; k++) v[k] <= 1'b0;
    end else if (ce) begin
      v[0] <= in_valid;
      for (int k = 0; k < POW_STAGES; k++) v[k+1] <= v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p[0]  <= Q16_ONE;
      r[0]  <= ratio;
      sd[0] <= in_side;
      for (int k = 0; k < POW_STAGES; k++) begin
        p[k+1]  <= p_nx[k];
        r[k+1]  <= r[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = v[POW_STAGES];
  assign power     = p[POW_STAGES];
  assign out_side  = sd[POW_STAGES];

endmodule

>>> sv/bgc_gain_div.sv
module bgc_gain_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic [bgc_pkg::Q16_W-1:0]   power,
  input  bgc_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [bgc_pkg::GAIN_W-1:0]  gain
);
  import bgc_pkg::*;

  logic                  v   [0:GAIN_STEPS];
  logic [Q16_W:0]        rem [0:GAIN_STEPS];
  logic [GAIN_STEPS-1:0] dvd [0:GAIN_STEPS];
  logic [GAIN_STEPS-1:0] quo [0:GAIN_STEPS];
  logic [Q16_W:0]        dn  [0:GAIN_STEPS];
  side_t                 sd  [0:GAIN_STEPS];

  logic [Q16_W+1:0] trial  [0:GAIN_STEPS-1];
  logic [Q16_W+1:0] diff   [0:GAIN_STEPS-1];
  logic             ge     [0:GAIN_STEPS-1];
  logic [Q16_W:0]   rem_nx [0:GAIN_STEPS-1];

  logic [Q16_W:0]   den_in;
  logic [Q16_W+1:0] x_in;

  // 2^32 plus half the divisor, so the quotient comes out rounded
  assign den_in = {1'b0, power} + {1'b0, Q16_ONE};
  assign x_in   = (Q16_W+2)'(34'h1_0000_0000) + {2'b0, den_in[Q16_W:1]};

  always_comb begin
    for (int k = 0; k < GAIN_STEPS; k++) begin
      trial[k]  = {rem[k], dvd[k][GAIN_STEPS-1]};
      diff[k]   = trial[k] - {1'b0, dn[k]};
      ge[k]     = trial[k] >= {1'b0, dn[k]};
      rem_nx[k] = ge[k] ? diff[k][Q16_W:0] : trial[k][Q16_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= GAIN_STEPS; k++) v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v[0] <= in_valid;
      for (int k = 0; k < GAIN_STEPS; k++) v[k+1] <= v[k];
      out_valid <= v[GAIN_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= {16'b0, x_in[Q16_W+1:GAIN_STEPS]};
      dvd[0] <= x_in[GAIN_STEPS-1:0];
      quo[0] <= '0;
      dn[0]  <= den_in;
      sd[0]  <= in_side;
      for (int k = 0; k < GAIN_STEPS; k++) begin
        rem[k+1] <= rem_nx[k];
        dvd[k+1] <= {dvd[k][GAIN_STEPS-2:0], 1'b0};
        quo[k+1] <= {quo[k][GAIN_STEPS-2:0], ge[k]};
        dn[k+1]  <= dn[k];
        sd[k+1]  <= sd[k];
      end
      if (sd[GAIN_STEPS].force_en) begin
        gain <= sd[GAIN_STEPS].force_val;
      end else if (sd[GAIN_STEPS].notch) begin
        gain <= GAIN_ONE - quo[GAIN_STEPS];
      end else begin
        gain <= quo[GAIN_STEPS];
      end
    end
  end

endmodule

>>> sv/butterworth_gain_curve_core.sv
// Squared Butterworth gain per frequency bin, unsigned Q1.16 on m_axis_tdata[16:0]
// (65536 is exactly one). One bin is accepted every clock unless the output stalls;
// each result passes the product and operand-select registers, the Q16.16 ratio
// divider (one quotient bit a stage), the power chain (one 32x32 multiply a stage,
// up to 62 multiplies for order 31) and the rounded reciprocal divider and output
// register. A stall on m_axis_tready holds the whole pipeline; a one-entry skid buffer
// keeps s_axis_tready registered. Write configuration only while no bin is in flight.
`include "assert_macros.svh"

module butterworth_gain_curve_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // frequency[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // gain_squared[16:0], zeros above
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bgc_pkg::*;

  mode_t               filter_mode;
  logic [FREQ_W-1:0]   low_cutoff;
  logic [FREQ_W-1:0]   high_cutoff;
  logic [ORDER_W-1:0]  filter_order;

  logic              skid_full;
  logic [FREQ_W-1:0] skid_freq;
  logic              ce;
  logic              in_v;
  logic [FREQ_W-1:0] in_f;
  side_t             in_side;

  logic              s1_v;
  logic [FREQ_W-1:0] s1_f;
  logic [Q16_W-1:0]  s1_ff;
  logic [Q16_W-1:0]  s1_cc;
  logic [Q16_W-1:0]  s1_fd;
  side_t             s1_side;

  logic              s2_v;
  logic [Q16_W-1:0]  s2_num;
  logic [Q16_W-1:0]  s2_den;
  side_t             s2_side;

  logic              rd_v;
  logic [Q16_W-1:0]  rd_ratio;
  side_t             rd_side;
  logic              pw_v;
  logic [Q16_W-1:0]  pw_p;
  side_t             pw_side;
  logic [GAIN_W-1:0] gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_BAND;
      low_cutoff   <= '0;
      high_cutoff  <= '1;
      filter_order <= ORDER_W'(4);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:     filter_mode  <= mode_t'(cfg_data[1:0]);
        REG_LOW_CUT:  low_cutoff   <= cfg_data[FREQ_W-1:0];
        REG_HIGH_CUT: high_cutoff  <= cfg_data[FREQ_W-1:0];
        REG_ORDER:    filter_order <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_full;
  assign in_v          = skid_full || s_axis_tvalid;
  assign in_f          = skid_full ? skid_freq : s_axis_tdata[FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (ce) begin
      skid_full <= 1'b0;
    end else if (s_axis_tvalid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ce && s_axis_tvalid && !skid_full) begin
      skid_freq <= s_axis_tdata[FREQ_W-1:0];
    end
  end

  // fixed results for zero frequency, zero cutoff and empty band
  always_comb begin
    in_side = '{force_en: 1'b0, force_val: '0, notch: 1'b0};
    unique case (filter_mode)
      MODE_LOW: begin
        if (in_f == '0) begin
          in_side.force_en  = 1'b1;
          in_side.force_val = GAIN_ONE;
        end else if (high_cutoff == '0) begin
          in_side.force_en = 1'b1;
        end
      end
      MODE_HIGH: begin
        if (in_f == '0) begin
          in_side.force_en = 1'b1;
        end else if (low_cutoff == '0) begin
          in_side.force_en  = 1'b1;
          in_side.force_val = GAIN_ONE;
        end
      end
      MODE_NOTCH: begin
        in_side.notch = 1'b1;
        if (in_f == '0 || high_cutoff <= low_cutoff) begin
          in_side.force_en  = 1'b1;
          in_side.force_val = GAIN_ONE;
        end
      end
      default: begin
        if (in_f == '0 || high_cutoff <= low_cutoff) begin
          in_side.force_en = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (ce) begin
      s1_v <= in_v;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_f    <= in_f;
      s1_ff   <= {16'b0, in_f} * {16'b0, in_f};
      s1_cc   <= {16'b0, low_cutoff} * {16'b0, high_cutoff};
      s1_fd   <= {16'b0, in_f} * {16'b0, high_cutoff - low_cutoff};
      s1_side <= in_side;
      s2_side <= s1_side;
      unique case (filter_mode)
        MODE_LOW: begin
          s2_num <= {16'b0, s1_f};
          s2_den <= {16'b0, high_cutoff};
        end
        MODE_HIGH: begin
          s2_num <= {16'b0, low_cutoff};
          s2_den <= {16'b0, s1_f};
        end
        default: begin
          s2_num <= (s1_ff >= s1_cc) ? s1_ff - s1_cc : s1_cc - s1_ff;
          s2_den <= s1_fd;
        end
      endcase
    end
  end

  bgc_ratio_div u_ratio (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s2_v),
    .num       (s2_num),
    .den       (s2_den),
    .in_side   (s2_side),
    .out_valid (rd_v),
    .ratio     (rd_ratio),
    .out_side  (rd_side)
  );

  bgc_power u_power (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .order     (filter_order),
    .in_valid  (rd_v),
    .ratio     (rd_ratio),
    .in_side   (rd_side),
    .out_valid (pw_v),
    .power     (pw_p),
    .out_side  (pw_side)
  );

  bgc_gain_div u_gain (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (pw_v),
    .power     (pw_p),
    .in_side   (pw_side),
    .out_valid (m_axis_tvalid),
    .gain      (gain)
  );

  assign m_axis_tdata = {7'b0, gain};

  `BGC_ASSERT(a_gain_range, clk, rst, m_axis_tvalid, gain <= GAIN_ONE)
  `BGC_ASSERT_NEXT(a_skid_hold, clk, rst, skid_full && !ce, skid_full && $stable(skid_freq))
  `BGC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !m_axis_tvalid && !skid_full)

endmodule

>>> bench/tb_top.sv
module tb_top;
  import bgc_pkg::*;

  localparam int LATENCY = 119;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // frequency[15:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;    // gain_squared[16:0], zeros above
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow of the block registers
  mode_t       cur_mode;
  logic [15:0] cur_low;
  logic [15:0] cur_high;
  logic [4:0]  cur_order;

  logic [16:0] gain_queue[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          stall_req;
  bit          stall_seen = 1'b0;
  int          stall_left = 0;

  butterworth_gain_curve_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // rounded, saturated num/den in q16.16
  function automatic logic [63:0] ratio_q16(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = (num << 16) / den;
    r = (num << 16) % den;
    if ((r << 1) >= den) q = q + 1;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q;
  endfunction

  function automatic logic [16:0] gain_of_ratio(logic [63:0] ratio);
    logic [63:0] p;
    logic [63:0] prod;
    logic [63:0] den;
    int          i;
    p = 64'h1_0000;
    for (i = 0; i < 2 * int'(cur_order); i++) begin
      prod = (p * ratio + 64'd32768) >> 16;
      p = (prod > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : prod;
    end
    den = 64'h1_0000 + p;
    return 17'(((64'd1 << 32) + den / 2) / den);
  endfunction

  function automatic logic [16:0] band_gain(logic [15:0] f);
    logic [63:0] ff;
    logic [63:0] cc;
    logic [63:0] num;
    if (f == 0 || cur_high <= cur_low) return 17'd0;
    ff = 64'(f) * 64'(f);
    cc = 64'(cur_low) * 64'(cur_high);
    num = (ff >= cc) ? ff - cc : cc - ff;
    return gain_of_ratio(ratio_q16(num, 64'(f) * 64'(cur_high - cur_low)));
  endfunction

  function automatic logic [16:0] predict_gain(logic [15:0] f);
    case (cur_mode)
      MODE_LOW: begin
        if (f == 0) return GAIN_ONE;
        if (cur_high == 0) return 17'd0;
        return gain_of_ratio(ratio_q16(64'(f), 64'(cur_high)));
      end
      MODE_HIGH: begin
        if (f == 0) return 17'd0;
        if (cur_low == 0) return GAIN_ONE;
        return gain_of_ratio(ratio_q16(64'(cur_low), 64'(f)));
      end
      MODE_NOTCH: return GAIN_ONE - band_gain(f);
      default: return band_gain(f);
    endcase
  endfunction

  // receiver: random idling plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= 600;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 12);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [16:0] exp_gain;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (gain_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 m_axis_tdata[16:0]);
        mismatches++;
      end else begin
        exp_gain = gain_queue.pop_front();
        if (m_axis_tdata[16:0] !== exp_gain) begin
          $display("%0t: gain mismatch, expected %0d, actual %0d", $time, exp_gain,
                   m_axis_tdata[16:0]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:     cur_mode  = mode_t'(value[1:0]);
      REG_LOW_CUT:  cur_low   = value;
      REG_HIGH_CUT: cur_high  = value;
      default:      cur_order = value[4:0];
    endcase
  endtask

  task automatic set_filter(mode_t m, logic [15:0] lo, logic [15:0] hi, logic [15:0] ord);
    write_reg(REG_MODE, 16'(m));
    write_reg(REG_LOW_CUT, lo);
    write_reg(REG_HIGH_CUT, hi);
    write_reg(REG_ORDER, ord);
  endtask

  task automatic send_bin(logic [15:0] f);
    if (tx_idle_on && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    do @(posedge clk); while (!s_axis_tready);
    gain_queue.push_back(predict_gain(f));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (gain_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_freq();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 16'($urandom);
    if (sel < 60) return 16'($urandom_range(0, 255));
    if (sel < 80) return cur_low + 16'($urandom_range(0, 64)) - 16'd32;
    return cur_high + 16'($urandom_range(0, 64)) - 16'd32;
  endfunction

  task automatic test_directed;
    logic [15:0] edges[6];
    edges = '{16'd0, 16'd1, 16'd1000, 16'd4000, 16'd32768, 16'hFFFF};
    // reset values: band-pass 0..65535, order 4
    foreach (edges[i]) send_bin(edges[i]);
    drain();
    set_filter(MODE_LOW, 16'd0, 16'd0, 16'd4);
    send_bin(16'd0); send_bin(16'd7);
    drain();
    set_filter(MODE_HIGH, 16'd0, 16'd1000, 16'd16);
    send_bin(16'd0); send_bin(16'hFFFF);
    drain();
    set_filter(MODE_NOTCH, 16'd3000, 16'd3000, 16'd2);
    send_bin(16'd0); send_bin(16'd3000);
    drain();
    set_filter(MODE_BAND, 16'd1000, 16'd4000, 16'd0);
    send_bin(16'd2000); send_bin(16'd0);
    drain();
    set_filter(MODE_LOW, 16'd0, 16'hFFFF, 16'hFFFF);
    send_bin(16'd1); send_bin(16'hFFFF); send_bin(16'd65000);
    drain();
    set_filter(MODE_HIGH, 16'hFFFF, 16'hFFFF, 16'd16);
    send_bin(16'd1); send_bin(16'hFFFF);
    drain();
  endtask

  task automatic random_phase(int count);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] ord;
    lo  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
    hi  = ($urandom_range(9) == 0) ? 16'($urandom) : lo + 16'($urandom_range(1, 20000));
    ord = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
    set_filter(mode_t'($urandom_range(3)), lo, hi, ord);
    repeat (count) send_bin(pick_freq());
    drain();
  endtask

  task automatic test_random;
    repeat (10) random_phase(110);
  endtask

  task automatic test_no_idle;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(150);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure;
    set_filter(MODE_BAND, 16'd500, 16'd2500, 16'd3);
    stall_req <= ~stall_req;
    repeat (200) send_bin(pick_freq());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = '0;
    cur_mode  = MODE_BAND;
    cur_low   = 16'd0;
    cur_high  = 16'hFFFF;
    cur_order = 5'd4;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    stall_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_no_idle();
    test_backpressure();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> butterworth_gain_curve_core.f
+incdir+sv
sv/bgc_pkg.sv
sv/bgc_ratio_div.sv
sv/bgc_power.sv
sv/bgc_gain_div.sv
sv/butterworth_gain_curve_core.sv
bench/tb_top.sv
